### hdl/e2q_pkg.sv
// Shared types, constants and arithmetic helpers for the Euler-to-quaternion unit.
package e2q_pkg;

    // Field widths
    localparam int ANGLE_W    = 16;
    localparam int COMP_W     = 16;

    // Fixed-point formats
    localparam int TRIG_FRAC   = 14;
    localparam int TRIG_W      = TRIG_FRAC + 2;
    localparam int MAG_W       = TRIG_FRAC + 1;
    localparam int QUAT_FRAC   = COMP_W - 2;
    localparam int PROD_FRAC   = 3 * TRIG_FRAC;
    localparam int ROUND_SHIFT = PROD_FRAC - QUAT_FRAC;
    localparam int PAIR_W      = 2 * TRIG_W;
    localparam int TRIPLE_W    = 3 * TRIG_W;

    // Angle reduction, half angle in 1/128 degree
    localparam int TURN_W    = 16;
    localparam int REM_W     = 14;
    localparam int FOLD_W    = 13;
    localparam logic [TURN_W-1:0] TURN_UNITS    = 16'd46080;
    localparam logic [TURN_W-1:0] QUARTER_UNITS = 16'd11520;
    localparam logic [TURN_W-1:0] HALF_UNITS    = 16'd23040;
    localparam logic [TURN_W-1:0] THREE_Q_UNITS = 16'd34560;
    localparam logic [REM_W-1:0]  OCTANT_UNITS  = 14'd5760;
    localparam logic [REM_W-1:0]  QUARTER_REM   = 14'd11520;

    // Quadrant codes
    typedef enum logic [1:0] {
        QUAD_0 = 2'd0,
        QUAD_1 = 2'd1,
        QUAD_2 = 2'd2,
        QUAD_3 = 2'd3
    } e2q_quad_t;

    // Series arithmetic, unsigned Q0.31 in 32 bits
    localparam int FX_W = 32;
    localparam logic [FX_W-1:0] ONE_Q31 = 32'h8000_0000;
    localparam int SERIES_TERMS = 6;
    localparam int DIV_SHIFT    = 40;
    localparam int RECIP_W      = 40;
    localparam int DIVISOR_W    = 8;

    localparam logic [DIVISOR_W-1:0] SIN_DIV [SERIES_TERMS] =
        '{8'd156, 8'd110, 8'd72, 8'd42, 8'd20, 8'd6};
    localparam logic [DIVISOR_W-1:0] COS_DIV [SERIES_TERMS] =
        '{8'd132, 8'd90, 8'd56, 8'd30, 8'd12, 8'd2};

    // Reciprocals ceil(2^40 / d), exact floor division for 32-bit dividends
    localparam logic [RECIP_W-1:0] SIN_RECIP [SERIES_TERMS] = '{
        RECIP_W'(((64'd1 << DIV_SHIFT) + 64'd155) / 64'd156),
        RECIP_W'(((64'd1 << DIV_SHIFT) + 64'd109) / 64'd110),
        RECIP_W'(((64'd1 << DIV_SHIFT) + 64'd71)  / 64'd72),
        RECIP_W'(((64'd1 << DIV_SHIFT) + 64'd41)  / 64'd42),
        RECIP_W'(((64'd1 << DIV_SHIFT) + 64'd19)  / 64'd20),
        RECIP_W'(((64'd1 << DIV_SHIFT) + 64'd5)   / 64'd6)
    };
    localparam logic [RECIP_W-1:0] COS_RECIP [SERIES_TERMS] = '{
        RECIP_W'(((64'd1 << DIV_SHIFT) + 64'd131) / 64'd132),
        RECIP_W'(((64'd1 << DIV_SHIFT) + 64'd89)  / 64'd90),
        RECIP_W'(((64'd1 << DIV_SHIFT) + 64'd55)  / 64'd56),
        RECIP_W'(((64'd1 << DIV_SHIFT) + 64'd29)  / 64'd30),
        RECIP_W'(((64'd1 << DIV_SHIFT) + 64'd11)  / 64'd12),
        RECIP_W'(((64'd1 << DIV_SHIFT) + 64'd1)   / 64'd2)
    };

    // Pipeline depths
    localparam int REDUCE_LAT = 7;
    localparam int SERIES_LAT = 2 * SERIES_TERMS + 1;
    localparam int TRIG_LAT   = REDUCE_LAT + SERIES_LAT + 1;
    localparam int COMB_LAT   = 4;
    localparam int TOTAL_LAT  = TRIG_LAT + COMB_LAT;

    // Beat types
    typedef struct packed {
        logic signed [ANGLE_W-1:0] pitch_angle;
        logic signed [ANGLE_W-1:0] roll_angle;
        logic signed [ANGLE_W-1:0] yaw_angle;
    } e2q_in_t;

    typedef struct packed {
        logic signed [COMP_W-1:0] quat_w;
        logic signed [COMP_W-1:0] quat_x;
        logic signed [COMP_W-1:0] quat_y;
        logic signed [COMP_W-1:0] quat_z;
    } e2q_out_t;

    // Q0.31 multiply, round to nearest
    function automatic logic [FX_W-1:0] mul31(input logic [FX_W-1:0] a,
                                              input logic [FX_W-1:0] b);
        logic [2*FX_W-1:0] p;
        p = 64'(a) * 64'(b) + (64'd1 << 30);
        return p[62:31];
    endfunction

endpackage

### hdl/euler_to_quaternion_unit.sv
// Each accepted start yields one done strobe, in the order the beats were accepted.
// Throughput: one beat per cycle; busy stays low and a new beat may start every cycle.
// The six-term sine/cosine series takes two pipeline stages per term.
// Results appear for one cycle on done; the receiver cannot stall the pipeline.
// Reset (rst_n, asynchronous, active low) clears the valid bits; data registers are not reset.
module euler_to_quaternion_unit
    import e2q_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    output logic     busy,
    input  e2q_in_t  angles,
    output logic     done,
    output e2q_out_t quat
);

    logic [TOTAL_LAT-1:0]     valid_reg;
    logic [TOTAL_LAT-1:0]     valid_next;
    logic signed [TRIG_W-1:0] sp, cp, sr, cr, sy, cy;

    // three identical half-angle units
    e2q_trig u_trig_pitch (
        .clk     (clk),
        .angle   (angles.pitch_angle),
        .sin_out (sp),
        .cos_out (cp)
    );

    e2q_trig u_trig_roll (
        .clk     (clk),
        .angle   (angles.roll_angle),
        .sin_out (sr),
        .cos_out (cr)
    );

    e2q_trig u_trig_yaw (
        .clk     (clk),
        .angle   (angles.yaw_angle),
        .sin_out (sy),
        .cos_out (cy)
    );

    e2q_combine u_combine (
        .clk  (clk),
        .sp   (sp),
        .cp   (cp),
        .sr   (sr),
        .cr   (cr),
        .sy   (sy),
        .cy   (cy),
        .quat (quat)
    );

    // beat valid travels alongside the data
    assign valid_next = {valid_reg[TOTAL_LAT-2:0], start & ~busy};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign busy = 1'b0;
    assign done = valid_reg[TOTAL_LAT-1];

endmodule

### hdl/e2q_reduce.sv
// Half-angle reduction to the first octant and conversion to radians in Q0.31.
module e2q_reduce
    import e2q_pkg::*;
(
    input  logic                      clk,
    input  logic signed [ANGLE_W-1:0] angle,
    output logic [FX_W-1:0]           x,
    output logic [FX_W-1:0]           x2,
    output e2q_quad_t                 quad,
    output logic                      swap
);

    // Offset to a non-negative multiple of a full turn
    localparam int UW      = ((ANGLE_W > 17) ? ANGLE_W : 17) + 1;
    localparam int VW      = UW - 10;
    localparam int RED_K   = VW + 6;
    localparam int RED_MW  = VW + 1;
    localparam longint unsigned OFF_TURNS =
        ((64'd1 << (ANGLE_W - 1)) + 64'd46079) / 64'd46080;
    localparam logic [UW-1:0] OFFSET = UW'(OFF_TURNS * 64'd46080);
    localparam logic [RED_MW-1:0] RED_M =
        RED_MW'(((64'd1 << RED_K) + 64'd44) / 64'd45);

    // Radians: r * pi / 23040 split into quotient and remainder parts
    localparam longint unsigned PI_Q48 = 64'h3243F6A8885A3;
    localparam int QW = 36;
    localparam int RW = 15;
    localparam logic [QW-1:0] RAD_Q = QW'(PI_Q48 / 64'd23040);
    localparam logic [RW-1:0] RAD_R = RW'(PI_Q48 % 64'd23040);
    localparam int RQ_W  = FOLD_W + QW;
    localparam int RR_W  = FOLD_W + RW;
    localparam int V2_W  = 18;
    localparam int M2_W  = 19;
    localparam logic [M2_W-1:0] RAD_M = M2_W'(((64'd1 << 24) + 64'd44) / 64'd45);

    logic [VW-1:0]        v1_reg;
    logic [9:0]           low1_reg;
    logic [2*VW:0]        prod1_reg;
    logic [TURN_W-1:0]    m2_reg;
    logic [FOLD_W-1:0]    ra3_reg;
    e2q_quad_t            quad_reg [3:7];
    logic                 swap_reg [3:7];
    logic [RQ_W-1:0]      rq4_reg;
    logic [RR_W-1:0]      rr4_reg;
    logic [RQ_W-1:0]      rq5_reg;
    logic [V2_W+M2_W-1:0] mq5_reg;
    logic [FX_W-1:0]      x6_reg;
    logic [FX_W-1:0]      x7_reg;
    logic [FX_W-1:0]      x2_7_reg;

    logic [UW-1:0]        u;
    logic [2*VW-RED_K:0]  q45;
    logic [VW-1:0]        rem_full;
    logic [TURN_W-1:0]    r_full;
    logic [REM_W-1:0]     r3;
    e2q_quad_t            quad_next;
    logic [V2_W-1:0]      v2;
    logic [RQ_W-1:0]      x48;
    logic [RQ_W-1:0]      x48_rnd;

    always_comb
    begin
        u        = UW'(signed'(angle)) + OFFSET;
        q45      = prod1_reg[2*VW:RED_K];
        rem_full = v1_reg - VW'(q45) * VW'(45);
        // quadrant of the half angle within a full turn
        if (m2_reg >= THREE_Q_UNITS)
        begin
            quad_next = QUAD_3;
            r_full    = m2_reg - THREE_Q_UNITS;
        end
        else if (m2_reg >= HALF_UNITS)
        begin
            quad_next = QUAD_2;
            r_full    = m2_reg - HALF_UNITS;
        end
        else if (m2_reg >= QUARTER_UNITS)
        begin
            quad_next = QUAD_1;
            r_full    = m2_reg - QUARTER_UNITS;
        end
        else
        begin
            quad_next = QUAD_0;
            r_full    = m2_reg;
        end
        r3      = r_full[REM_W-1:0];
        v2      = V2_W'((RR_W'(rr4_reg) + RR_W'(11520)) >> 9);
        x48     = rq5_reg + RQ_W'(mq5_reg >> 24);
        x48_rnd = x48 + (RQ_W'(1) << 16);
    end

    always_ff @(posedge clk)
    begin
        // turn count by reciprocal
        v1_reg    <= u[UW-1:10];
        low1_reg  <= u[9:0];
        prod1_reg <= (2*VW+1)'(u[UW-1:10]) * (2*VW+1)'(RED_M);
        // remainder modulo a full turn
        m2_reg    <= {rem_full[5:0], low1_reg};
        // fold into the first octant
        quad_reg[3] <= quad_next;
        if (r3 <= OCTANT_UNITS)
        begin
            ra3_reg     <= r3[FOLD_W-1:0];
            swap_reg[3] <= 1'b0;
        end
        else
        begin
            ra3_reg     <= FOLD_W'(QUARTER_REM - r3);
            swap_reg[3] <= 1'b1;
        end
        for (int i = 4; i <= 7; i++)
        begin
            quad_reg[i] <= quad_reg[i-1];
            swap_reg[i] <= swap_reg[i-1];
        end
        // radians
        rq4_reg  <= RQ_W'(ra3_reg) * RQ_W'(RAD_Q);
        rr4_reg  <= RR_W'(ra3_reg) * RR_W'(RAD_R);
        rq5_reg  <= rq4_reg;
        mq5_reg  <= (V2_W+M2_W)'(v2) * (V2_W+M2_W)'(RAD_M);
        x6_reg   <= x48_rnd[48:17];
        x7_reg   <= x6_reg;
        x2_7_reg <= mul31(x6_reg, x6_reg);
    end

    assign x    = x7_reg;
    assign x2   = x2_7_reg;
    assign quad = quad_reg[7];
    assign swap = swap_reg[7];

endmodule

### hdl/e2q_series.sv
// Pipelined Horner-form Taylor series for sine and cosine of a first-octant angle.
module e2q_series
    import e2q_pkg::*;
(
    input  logic             clk,
    input  logic [FX_W-1:0]  x,
    input  logic [FX_W-1:0]  x2,
    output logic [MAG_W-1:0] sin_mag,
    output logic [MAG_W-1:0] cos_mag
);

    localparam int DEPTH = 2 * SERIES_TERMS;

    logic [FX_W-1:0]  x_d_reg  [1:DEPTH];
    logic [FX_W-1:0]  x2_d_reg [1:DEPTH];
    logic [FX_W-1:0]  x_at     [0:DEPTH];
    logic [FX_W-1:0]  x2_at    [0:DEPTH];
    logic [FX_W-1:0]  ts       [0:SERIES_TERMS];
    logic [FX_W-1:0]  tc       [0:SERIES_TERMS];
    logic [FX_W-1:0]  ps_reg   [0:SERIES_TERMS-1];
    logic [FX_W-1:0]  pc_reg   [0:SERIES_TERMS-1];
    logic [FX_W-1:0]  ts_reg   [1:SERIES_TERMS];
    logic [FX_W-1:0]  tc_reg   [1:SERIES_TERMS];
    logic [MAG_W-1:0] sin_reg;
    logic [MAG_W-1:0] cos_reg;
    logic [FX_W-1:0]  sin_full;

    function automatic logic [FX_W-1:0] div_round(input logic [FX_W-1:0]      p,
                                                  input logic [DIVISOR_W-1:0] d,
                                                  input logic [RECIP_W-1:0]   m);
        logic [FX_W-1:0]         n;
        logic [FX_W+RECIP_W-1:0] prod;
        n    = p + FX_W'(d >> 1);
        prod = (FX_W+RECIP_W)'(n) * (FX_W+RECIP_W)'(m);
        return prod[FX_W+RECIP_W-1:DIV_SHIFT];
    endfunction

    function automatic logic [MAG_W-1:0] to_q14(input logic [FX_W-1:0] t);
        logic [FX_W-1:0] s;
        s = t + (FX_W'(1) << 16);
        return s[FX_W-1:17];
    endfunction

    assign x_at[0]  = x;
    assign x2_at[0] = x2;
    assign ts[0]    = ONE_Q31;
    assign tc[0]    = ONE_Q31;

    genvar g;
    generate
        for (g = 1; g <= DEPTH; g++)
        begin : g_tap
            assign x_at[g]  = x_d_reg[g];
            assign x2_at[g] = x2_d_reg[g];
        end
        for (g = 1; g <= SERIES_TERMS; g++)
        begin : g_term
            assign ts[g] = ts_reg[g];
            assign tc[g] = tc_reg[g];
        end
        // one term: multiply stage then divide-and-subtract stage
        for (g = 0; g < SERIES_TERMS; g++)
        begin : g_iter
            always_ff @(posedge clk)
            begin
                ps_reg[g]   <= mul31(x2_at[2*g], ts[g]);
                pc_reg[g]   <= mul31(x2_at[2*g], tc[g]);
                ts_reg[g+1] <= ONE_Q31 - div_round(ps_reg[g], SIN_DIV[g], SIN_RECIP[g]);
                tc_reg[g+1] <= ONE_Q31 - div_round(pc_reg[g], COS_DIV[g], COS_RECIP[g]);
            end
        end
    endgenerate

    // operand delay lines
    always_ff @(posedge clk)
    begin
        for (int i = 1; i <= DEPTH; i++)
        begin
            x_d_reg[i]  <= x_at[i-1];
            x2_d_reg[i] <= x2_at[i-1];
        end
    end

    // final sine scaling and rounding to Q1.14
    assign sin_full = mul31(x_at[DEPTH], ts[SERIES_TERMS]);

    always_ff @(posedge clk)
    begin
        sin_reg <= to_q14(sin_full);
        cos_reg <= to_q14(tc[SERIES_TERMS]);
    end

    assign sin_mag = sin_reg;
    assign cos_mag = cos_reg;

endmodule

### hdl/e2q_trig.sv
// Signed half-angle sine and cosine in Q1.14 for one input angle.
module e2q_trig
    import e2q_pkg::*;
(
    input  logic                      clk,
    input  logic signed [ANGLE_W-1:0] angle,
    output logic signed [TRIG_W-1:0]  sin_out,
    output logic signed [TRIG_W-1:0]  cos_out
);

    logic [FX_W-1:0]  x;
    logic [FX_W-1:0]  x2;
    e2q_quad_t        quad;
    logic             swap;
    logic [MAG_W-1:0] sin_mag;
    logic [MAG_W-1:0] cos_mag;
    e2q_quad_t        quad_reg [1:SERIES_LAT];
    logic             swap_reg [1:SERIES_LAT];
    logic signed [TRIG_W-1:0] sin_reg;
    logic signed [TRIG_W-1:0] cos_reg;
    logic signed [TRIG_W-1:0] sm;
    logic signed [TRIG_W-1:0] cm;
    logic signed [TRIG_W-1:0] sin_next;
    logic signed [TRIG_W-1:0] cos_next;

    e2q_reduce u_reduce (
        .clk   (clk),
        .angle (angle),
        .x     (x),
        .x2    (x2),
        .quad  (quad),
        .swap  (swap)
    );

    e2q_series u_series (
        .clk     (clk),
        .x       (x),
        .x2      (x2),
        .sin_mag (sin_mag),
        .cos_mag (cos_mag)
    );

    // quadrant and fold flags follow the series
    always_ff @(posedge clk)
    begin
        quad_reg[1] <= quad;
        swap_reg[1] <= swap;
        for (int i = 2; i <= SERIES_LAT; i++)
        begin
            quad_reg[i] <= quad_reg[i-1];
            swap_reg[i] <= swap_reg[i-1];
        end
    end

    // undo the fold and apply the quadrant signs
    always_comb
    begin
        if (swap_reg[SERIES_LAT])
        begin
            sm = signed'(TRIG_W'(cos_mag));
            cm = signed'(TRIG_W'(sin_mag));
        end
        else
        begin
            sm = signed'(TRIG_W'(sin_mag));
            cm = signed'(TRIG_W'(cos_mag));
        end
        unique case (quad_reg[SERIES_LAT])
            QUAD_0:
            begin
                sin_next = sm;
                cos_next = cm;
            end
            QUAD_1:
            begin
                sin_next = cm;
                cos_next = -sm;
            end
            QUAD_2:
            begin
                sin_next = -sm;
                cos_next = -cm;
            end
            default:
            begin
                sin_next = -cm;
                cos_next = sm;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        sin_reg <= sin_next;
        cos_reg <= cos_next;
    end

    assign sin_out = sin_reg;
    assign cos_out = cos_reg;

endmodule

### hdl/e2q_combine.sv
// Triple-product sums, rounding and saturation of the quaternion parts.
module e2q_combine
    import e2q_pkg::*;
(
    input  logic                     clk,
    input  logic signed [TRIG_W-1:0] sp,
    input  logic signed [TRIG_W-1:0] cp,
    input  logic signed [TRIG_W-1:0] sr,
    input  logic signed [TRIG_W-1:0] cr,
    input  logic signed [TRIG_W-1:0] sy,
    input  logic signed [TRIG_W-1:0] cy,
    output e2q_out_t                 quat
);

    localparam logic [TRIPLE_W-1:0] HALF_LSB = TRIPLE_W'(1) << (ROUND_SHIFT - 1);
    localparam logic [TRIPLE_W-1:0] ONE_OUT  = TRIPLE_W'(1) << QUAT_FRAC;

    logic signed [PAIR_W-1:0]   crcp_reg, srsp_reg, crsp_reg, srcp_reg;
    logic signed [TRIG_W-1:0]   cy_reg, sy_reg;
    logic signed [TRIPLE_W-1:0] w1_reg, w2_reg, x1_reg, x2_reg;
    logic signed [TRIPLE_W-1:0] y1_reg, y2_reg, z1_reg, z2_reg;
    logic signed [TRIPLE_W-1:0] w_reg, x_reg, y_reg, z_reg;
    e2q_out_t                   quat_reg;

    function automatic logic [COMP_W-1:0] finish(input logic signed [TRIPLE_W-1:0] sum);
        logic                neg;
        logic [TRIPLE_W-1:0] mag;
        logic [TRIPLE_W-1:0] v;
        neg = sum[TRIPLE_W-1];
        mag = neg ? (TRIPLE_W'(0) - TRIPLE_W'(sum)) : TRIPLE_W'(sum);
        v   = (mag + HALF_LSB) >> ROUND_SHIFT;
        if (v > ONE_OUT)
        begin
            v = ONE_OUT;
        end
        if (neg)
        begin
            v = TRIPLE_W'(0) - v;
        end
        return v[COMP_W-1:0];
    endfunction

    always_ff @(posedge clk)
    begin
        // pair products
        crcp_reg <= PAIR_W'(cr) * PAIR_W'(cp);
        srsp_reg <= PAIR_W'(sr) * PAIR_W'(sp);
        crsp_reg <= PAIR_W'(cr) * PAIR_W'(sp);
        srcp_reg <= PAIR_W'(sr) * PAIR_W'(cp);
        cy_reg   <= cy;
        sy_reg   <= sy;
        // triple products
        w1_reg <= TRIPLE_W'(crcp_reg) * TRIPLE_W'(cy_reg);
        w2_reg <= TRIPLE_W'(srsp_reg) * TRIPLE_W'(sy_reg);
        x1_reg <= TRIPLE_W'(crsp_reg) * TRIPLE_W'(cy_reg);
        x2_reg <= TRIPLE_W'(srcp_reg) * TRIPLE_W'(sy_reg);
        y1_reg <= TRIPLE_W'(srcp_reg) * TRIPLE_W'(cy_reg);
        y2_reg <= TRIPLE_W'(crsp_reg) * TRIPLE_W'(sy_reg);
        z1_reg <= TRIPLE_W'(crcp_reg) * TRIPLE_W'(sy_reg);
        z2_reg <= TRIPLE_W'(srsp_reg) * TRIPLE_W'(cy_reg);
        // sums
        w_reg <= w1_reg + w2_reg;
        x_reg <= x1_reg + x2_reg;
        y_reg <= y1_reg - y2_reg;
        z_reg <= z1_reg - z2_reg;
        // round and saturate
        quat_reg.quat_w <= signed'(finish(w_reg));
        quat_reg.quat_x <= signed'(finish(x_reg));
        quat_reg.quat_y <= signed'(finish(y_reg));
        quat_reg.quat_z <= signed'(finish(z_reg));
    end

    assign quat = quat_reg;

endmodule

### tb/tb_euler_to_quaternion_unit.sv
// Self-checking testbench for the Euler-angle to quaternion conversion unit.
`timescale 1ns / 1ps

module tb_euler_to_quaternion_unit
    import e2q_pkg::*;
;

    localparam int LATENCY     = TOTAL_LAT + 1;
    localparam int CYCLE_LIMIT = 200000;
    localparam int N_RANDOM    = 1300;
    localparam int N_DIRECTED  = 20;

    logic     clk = 1'b0;
    logic     rst_n = 1'b0;
    logic     start = 1'b0;
    logic     busy;
    e2q_in_t  angles = '0;
    logic     done;
    e2q_out_t quat;

    e2q_out_t quat_expected_q[$];
    int       mismatch_count = 0;
    int       cycle_count = 0;
    bit       stim_done = 1'b0;

    euler_to_quaternion_unit u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .angles (angles),
        .done   (done),
        .quat   (quat)
    );

    always #2 clk = ~clk;

    // Directed table: angles, and a typed-in answer where it is obvious
    typedef struct {
        logic signed [15:0] p, r, y;
        bit                 has_exp;
        e2q_out_t           exp_q;
    } dir_row_t;

    dir_row_t dir_tab [N_DIRECTED];

    initial
    begin
        dir_tab[0]  = '{16'sd0, 16'sd0, 16'sd0, 1'b1, '{16'sd16384, 16'sd0, 16'sd0, 16'sd0}};
        // 360 deg half-angle is 180 deg: w = -1
        dir_tab[1]  = '{16'sd23040, 16'sd0, 16'sd0, 1'b1, '{-16'sd16384, 16'sd0, 16'sd0, 16'sd0}};
        dir_tab[2]  = '{16'sd11520, 16'sd0, 16'sd0, 1'b1, '{16'sd0, 16'sd16384, 16'sd0, 16'sd0}};
        dir_tab[3]  = '{16'sd0, 16'sd11520, 16'sd0, 1'b1, '{16'sd0, 16'sd0, 16'sd16384, 16'sd0}};
        dir_tab[4]  = '{16'sd0, 16'sd0, 16'sd11520, 1'b1, '{16'sd0, 16'sd0, 16'sd0, 16'sd16384}};
        dir_tab[5]  = '{16'sd32767, 16'sd32767, 16'sd32767, 1'b0, '0};
        dir_tab[6]  = '{-16'sd32768, -16'sd32768, -16'sd32768, 1'b0, '0};
        dir_tab[7]  = '{-16'sd1, 16'sd1, -16'sd1, 1'b0, '0};
        dir_tab[8]  = '{16'sd5760, 16'sd5760, 16'sd5760, 1'b0, '0};
        dir_tab[9]  = '{16'sd5761, 16'sd5759, -16'sd5760, 1'b0, '0};
        dir_tab[10] = '{16'sd2880, -16'sd2880, 16'sd8640, 1'b0, '0};
        dir_tab[11] = '{-16'sd11520, 16'sd23040, 16'sd17280, 1'b0, '0};
        dir_tab[12] = '{16'sd17280, 16'sd17280, 16'sd17280, 1'b0, '0};
        dir_tab[13] = '{-16'sd23040, -16'sd11520, 16'sd11519, 1'b0, '0};
        dir_tab[14] = '{16'sd11521, -16'sd17281, 16'sd4000, 1'b0, '0};
        dir_tab[15] = '{16'sh5555, -16'sh5556, 16'sh2AAA, 1'b0, '0};
        dir_tab[16] = '{16'sd2880, 16'sd2880, 16'sd2880, 1'b0, '0};
        dir_tab[17] = '{16'sd30000, -16'sd30000, 16'sd12345, 1'b0, '0};
        dir_tab[18] = '{16'sd100, 16'sd200, 16'sd300, 1'b0, '0};
        dir_tab[19] = '{-16'sd23041, 16'sd23041, 16'sd0, 1'b0, '0};
    end

    // Q0.31 multiply, round to nearest
    function automatic longint unsigned fx_mul(longint unsigned a, longint unsigned b);
        return (a * b + (64'd1 << 30)) >> 31;
    endfunction

    // Taylor series magnitude in Q1.14 for an angle of r units in the first octant
    function automatic int series_mag(longint unsigned r, bit want_sin);
        longint unsigned rad, rad2, term, prod, dv;
        longint unsigned divs [6];
        if (want_sin)
            divs = '{156, 110, 72, 42, 20, 6};
        else
            divs = '{132, 90, 56, 30, 12, 2};
        rad  = (r * 64'h3243F6A8885A3 + 64'd11520) / 64'd23040;
        rad  = (rad + (64'd1 << 16)) >> 17;
        rad2 = fx_mul(rad, rad);
        term = 64'h8000_0000;
        for (int i = 0; i < 6; i++)
        begin
            dv   = divs[i];
            prod = fx_mul(rad2, term);
            term = 64'h8000_0000 - (prod + dv / 2) / dv;
        end
        if (want_sin)
            term = fx_mul(rad, term);
        return int'((term + (64'd1 << 16)) >> 17);
    endfunction

    // Sine and cosine of half the given angle
    function automatic void half_angle_trig(input logic signed [15:0] ang,
                                            output int s, output int c);
        int m, q, r, sm, cm;
        m = int'(ang) % 46080;
        if (m < 0)
            m += 46080;
        q = m / 11520;
        r = m % 11520;
        if (r <= 5760)
        begin
            sm = series_mag(r, 1'b1);
            cm = series_mag(r, 1'b0);
        end
        else
        begin
            sm = series_mag(11520 - r, 1'b0);
            cm = series_mag(11520 - r, 1'b1);
        end
        case (q)
            0:
            begin
                s = sm;
                c = cm;
            end
            1:
            begin
                s = cm;
                c = -sm;
            end
            2:
            begin
                s = -sm;
                c = -cm;
            end
            default:
            begin
                s = -cm;
                c = sm;
            end
        endcase
    endfunction

    // Round a Q3.42 sum to Q1.14, ties away from zero, saturate at one
    function automatic logic signed [15:0] round_component(longint sum);
        longint unsigned mag, v;
        bit neg;
        neg = sum < 0;
        mag = neg ? longint'(-sum) : sum;
        v   = (mag + (64'd1 << (ROUND_SHIFT - 1))) >> ROUND_SHIFT;
        if (v > (64'd1 << QUAT_FRAC))
            v = 64'd1 << QUAT_FRAC;
        return neg ? -16'(v) : 16'(v);
    endfunction

    function automatic e2q_out_t predict_quat(e2q_in_t a);
        int sp, cp, sr, cr, sy, cy;
        e2q_out_t o;
        half_angle_trig(a.pitch_angle, sp, cp);
        half_angle_trig(a.roll_angle, sr, cr);
        half_angle_trig(a.yaw_angle, sy, cy);
        o.quat_w = round_component(longint'(cr) * cp * cy + longint'(sr) * sp * sy);
        o.quat_x = round_component(longint'(cr) * sp * cy + longint'(sr) * cp * sy);
        o.quat_y = round_component(longint'(sr) * cp * cy - longint'(cr) * sp * sy);
        o.quat_z = round_component(longint'(cr) * cp * sy - longint'(sr) * sp * cy);
        return o;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatch_count++;
        $display("MISMATCH %s: got %0d expected %0d at cycle %0d", what, got, want, cycle_count);
    endtask

    // Present one beat, hold start until accepted
    task automatic send_beat(input e2q_in_t a);
        start  <= 1'b1;
        angles <= a;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic idle_burst();
        start <= 1'b0;
        repeat ($urandom_range(1, 15))
            @(posedge clk);
    endtask

    // Record expectation on each accepted beat
    always @(posedge clk)
    begin
        if (rst_n && start && !busy)
            quat_expected_q.push_back(predict_quat(angles));
    end

    // Result checker
    always @(posedge clk)
    begin
        e2q_out_t want;
        if (rst_n && done)
        begin
            if (quat_expected_q.size() == 0)
                report_mismatch("unexpected beat", 1, 0);
            else
            begin
                want = quat_expected_q.pop_front();
                if (quat.quat_w !== want.quat_w) report_mismatch("quat_w", quat.quat_w, want.quat_w);
                if (quat.quat_x !== want.quat_x) report_mismatch("quat_x", quat.quat_x, want.quat_x);
                if (quat.quat_y !== want.quat_y) report_mismatch("quat_y", quat.quat_y, want.quat_y);
                if (quat.quat_z !== want.quat_z) report_mismatch("quat_z", quat.quat_z, want.quat_z);
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // Random angle, biased towards octant and quadrant edges
    function automatic logic signed [15:0] rand_angle();
        int k;
        k = $urandom_range(0, 9);
        if (k == 0)
            return 16'(int'($urandom_range(0, 10)) * 5760 - 28800 + int'($urandom_range(0, 2)) - 1);
        return 16'($urandom);
    endfunction

    initial
    begin
        e2q_in_t a;
        int wait_n;
        repeat (6)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed rows, checked against typed answers where given
        for (int i = 0; i < N_DIRECTED; i++)
        begin
            a.pitch_angle = dir_tab[i].p;
            a.roll_angle  = dir_tab[i].r;
            a.yaw_angle   = dir_tab[i].y;
            if (dir_tab[i].has_exp && predict_quat(a) !== dir_tab[i].exp_q)
                report_mismatch("predictor row", i, 0);
            send_beat(a);
        end

        // Random beats with idle bursts, none towards the end
        for (int i = 0; i < N_RANDOM; i++)
        begin
            a.pitch_angle = rand_angle();
            a.roll_angle  = rand_angle();
            a.yaw_angle   = rand_angle();
            send_beat(a);
            if (i < N_RANDOM - 200 && $urandom_range(0, 7) == 0)
                idle_burst();
        end
        start <= 1'b0;

        wait_n = 0;
        while (quat_expected_q.size() != 0 && wait_n < 20 * LATENCY)
        begin
            @(posedge clk);
            wait_n++;
        end
        repeat (LATENCY)
            @(posedge clk);

        if (mismatch_count == 0 && quat_expected_q.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
